>>> hw/rtl/tclc_pkg.sv
// Shared types, constants and lookup functions for the two-channel lux calculator.
// Used by tclc_div and two_channel_lux_calculator; depends on nothing else.
`default_nettype none

package tclc_pkg;

  // Field and bus widths.
  localparam int CNT_W    = 16;
  localparam int STAT_W   = 8;
  localparam int LUX_W    = 26;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 32;
  localparam int CODE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int WSUM_W   = 32;
  localparam int DSR_W    = 16;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 16;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int STEP_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ITIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [CODE_W-1:0] ITIME_RST = 3'd3;
  localparam logic [CODE_W-1:0] RANGE_RST = 3'd3;

  // Status byte bit positions.
  localparam int ST_INVALID = 7;
  localparam int ST_NEW     = 2;
  localparam int ST_GAIN_LO = 4;

  // Ratio thresholds and band weights.
  localparam logic [MUL_B_W-1:0] RATIO_SCALE = 16'd1000;
  localparam logic [MUL_B_W-1:0] THR_BAND0   = 16'd450;
  localparam logic [MUL_B_W-1:0] THR_BAND1   = 16'd640;
  localparam logic [MUL_B_W-1:0] THR_BAND2   = 16'd850;
  localparam logic [MUL_B_W-1:0] K0_BAND0    = 16'd17743;
  localparam logic [MUL_B_W-1:0] K1_BAND0    = 16'd11059;
  localparam logic [MUL_B_W-1:0] K0_BAND1    = 16'd42785;
  localparam logic [MUL_B_W-1:0] K1_BAND1    = 16'd19548;
  localparam logic [MUL_B_W-1:0] K0_BAND2    = 16'd5926;
  localparam logic [MUL_B_W-1:0] K1_BAND2    = 16'd1185;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  // Analog gain from the status gain code; unused codes act as gain 1.
  function automatic logic [MUL_A_W-1:0] gain_of(input logic [CODE_W-1:0] code);
    logic [MUL_A_W-1:0] g;
    case (code)
      3'd1:    g = 17'd2;
      3'd2:    g = 17'd4;
      3'd3:    g = 17'd8;
      3'd6:    g = 17'd48;
      3'd7:    g = 17'd96;
      default: g = 17'd1;
    endcase
    return g;
  endfunction

  // Integration scaling times 100: 50 * (code + 1).
  function automatic logic [MUL_B_W-1:0] itime_scale(input logic [CODE_W-1:0] code);
    return MUL_B_W'(50 * (int'(code) + 1));
  endfunction

  // Clamp cap in hundredths of a lux for each range; ranges 6 and 7 have none.
  function automatic logic [LUX_W-1:0] cap_of(input logic [CODE_W-1:0] sel);
    logic [LUX_W-1:0] c;
    case (sel)
      3'd0:    c = 26'd6400000;
      3'd1:    c = 26'd3200000;
      3'd2:    c = 26'd1600000;
      3'd3:    c = 26'd800000;
      3'd4:    c = 26'd130000;
      3'd5:    c = 26'd60000;
      default: c = '1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tclc_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on tclc_pkg for widths.
`default_nettype none

module tclc_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [tclc_pkg::WSUM_W-1:0]  dividend,
  input  wire logic [tclc_pkg::DSR_W-1:0]   divisor,
  output logic                              done,
  output logic [tclc_pkg::WSUM_W-1:0]       quotient
);
  import tclc_pkg::*;

  localparam int CNT_BITS = $clog2(WSUM_W);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [DSR_W-1:0]      rem;
  logic [DSR_W-1:0]      dsr;
  logic [WSUM_W-1:0]     dvd;
  logic [DSR_W:0]        trial;
  logic [DSR_W:0]        diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem, dvd[WSUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(WSUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and the shifting dividend/quotient word.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd <= {dvd[WSUM_W-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

>>> hw/rtl/two_channel_lux_calculator.sv
// Top level of the two-channel lux calculator: sequencer, shared multiplier,
// configuration registers and output register. Depends on tclc_pkg and tclc_div.
//
//  Channel | Signals                               | Word
//  --------+---------------------------------------+----------------------------------
//  in      | s_axis_tvalid/tready/tdata[39:0]      | channel0, channel1, status byte
//  out     | m_axis_tvalid/tready/tdata[31:0]      | lux_hundredths, zero padded
//  cfg     | cfg_valid/ready, cfg_index, cfg_data  | register index and value
//
// A readout that produces a result is accepted in the idle state, takes eight steps on the
// shared 17x16 multiplier (ratio test, divisor, weighted sum), waits in the divide state
// for the 32 bit steps of the bit-serial divider and its done pulse, then loads the
// output register. Readouts without the new-data bit, or the one dropped after a
// configuration write, are accepted in the idle state and produce no result.
// Reset is synchronous and needs no clearing pass. The output register holds a result
// while the sink stalls; a new readout is taken meanwhile, and its result waits until
// the register is free.
`default_nettype none

module two_channel_lux_calculator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // channel0_count [15:0], channel1_count [31:16], status_byte [39:32]
  input  wire logic [tclc_pkg::IN_W-1:0]       s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lux_hundredths [25:0], zeros above
  output logic [tclc_pkg::OUT_W-1:0]           m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tclc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tclc_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import tclc_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = '1;

  state_t                state, state_next;
  logic [STEP_W-1:0]     step;
  logic [CODE_W-1:0]     itime;
  logic [CODE_W-1:0]     range_sel;
  logic                  discard_pending;
  logic [CNT_W-1:0]      ch0;
  logic [CNT_W-1:0]      ch1;
  logic [STAT_W-1:0]     status;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     scaled_ch1;
  logic                  lt_band0, lt_band1, lt_band2;
  logic [DSR_W-1:0]      divisor;
  logic [WSUM_W-1:0]     wsum, wsum_next;
  logic [LUX_W-1:0]      lux;
  logic [LUX_W-1:0]      lux_next;
  logic                  out_valid;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic                  in_accept, cfg_accept, take_item, out_free, load_out, div_start;
  logic                  div_done;
  logic [WSUM_W-1:0]     quotient;
  logic [LUX_W-1:0]      cap;
  logic [MUL_B_W-1:0]    k0, k1;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign take_item  = in_accept && s_axis_tdata[CNT_W*2 + ST_NEW] && !discard_pending;
  assign out_free   = !out_valid || m_axis_tready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take_item) state_next = ST_MUL;
      ST_MUL:  if (step == LAST_STEP) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_MUL:  div_start     = (step == LAST_STEP);
      ST_DIV:  ;
      ST_OUT:  load_out      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) step <= step + 1'b1;
      else                 step <= '0;
    end
  end

  // Configuration registers and the drop flag for the first readout after a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      itime           <= ITIME_RST;
      range_sel       <= RANGE_RST;
      discard_pending <= 1'b0;
    end else if (cfg_accept && (cfg_index == REG_ITIME)) begin
      itime           <= cfg_data[CODE_W-1:0];
      discard_pending <= 1'b1;
    end else if (cfg_accept && (cfg_index == REG_RANGE)) begin
      range_sel       <= cfg_data[CODE_W-1:0];
      discard_pending <= 1'b1;
    end else if (in_accept && s_axis_tdata[CNT_W*2 + ST_NEW]) begin
      discard_pending <= 1'b0;
    end
  end

  // Capture the readout fields.
  always_ff @(posedge clk) begin
    if (take_item) begin
      ch0    <= s_axis_tdata[CNT_W-1:0];
      ch1    <= s_axis_tdata[2*CNT_W-1:CNT_W];
      status <= s_axis_tdata[IN_W-1:2*CNT_W];
    end
  end

  // Band weights follow the ratio compares.
  always_comb begin
    if (lt_band0) begin
      k0 = K0_BAND0;
      k1 = K1_BAND0;
    end else if (lt_band1) begin
      k0 = K0_BAND1;
      k1 = K1_BAND1;
    end else if (lt_band2) begin
      k0 = K0_BAND2;
      k1 = K1_BAND2;
    end else begin
      k0 = '0;
      k1 = '0;
    end
  end

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    case (step)
      3'd0: begin mul_a = {1'b0, ch1};             mul_b = RATIO_SCALE; end
      3'd1: begin mul_a = {1'b0, ch0} + {1'b0, ch1}; mul_b = THR_BAND0; end
      3'd2: begin mul_a = {1'b0, ch0} + {1'b0, ch1}; mul_b = THR_BAND1; end
      3'd3: begin mul_a = {1'b0, ch0} + {1'b0, ch1}; mul_b = THR_BAND2; end
      3'd4: begin
        mul_a = gain_of(status[ST_GAIN_LO +: CODE_W]);
        mul_b = itime_scale(itime);
      end
      3'd5:    begin mul_a = {1'b0, ch0}; mul_b = k0; end
      3'd6:    begin mul_a = {1'b0, ch1}; mul_b = k1; end
      default: begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  // Band one subtracts the infrared term; the other bands add it.
  always_comb begin
    if (!lt_band0 && lt_band1) wsum_next = wsum - prod[WSUM_W-1:0];
    else                       wsum_next = wsum + prod[WSUM_W-1:0];
  end

  // Each step consumes the product registered in the step before.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      case (step)
        3'd1:    scaled_ch1 <= prod;
        3'd2:    lt_band0   <= scaled_ch1 < prod;
        3'd3:    lt_band1   <= scaled_ch1 < prod;
        3'd4:    lt_band2   <= scaled_ch1 < prod;
        3'd5:    divisor    <= prod[DSR_W-1:0];
        3'd6:    wsum       <= prod[WSUM_W-1:0];
        default: ;
      endcase
    end
  end

  tclc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wsum_next),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp to the range cap when the sensor flags the data invalid.
  assign cap = cap_of(range_sel);

  always_comb begin
    lux_next = quotient[LUX_W-1:0];
    if (status[ST_INVALID] && (range_sel <= 3'd5) && (quotient < WSUM_W'(cap)))
      lux_next = quotient[LUX_W-1:0];
    else if (status[ST_INVALID] && (range_sel <= 3'd5))
      lux_next = cap;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) lux <= lux_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - LUX_W){1'b0}}, lux};

  // The divider only finishes while the sequencer waits for it.
  a_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  // The last multiplier step always hands over to the divider.
  a_mul_to_div : assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MUL) && (step == LAST_STEP)) |=> (state == ST_DIV))
    else $error("multiply sequence did not start the divide");

  // A result is never loaded over one that the sink has not taken.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while stalled");

  // A register write always arms the drop of the next readout.
  a_cfg_arms_drop : assert property (@(posedge clk) disable iff (rst)
    (cfg_accept && ((cfg_index == REG_ITIME) || (cfg_index == REG_RANGE)))
      |=> discard_pending)
    else $error("configuration write did not arm the drop flag");

endmodule

`default_nettype wire
